[hdl/median_filter_3x3_unit_assert.svh]
// Assertion macros used by the checker of the median filter.
`ifndef MEDIAN_FILTER_3X3_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_3X3_UNIT_ASSERT_SVH

// Concurrent assertion that is switched off while reset is applied.
`define MF3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is applied.
`define MF3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mf3_pkg.sv]
package mf3_pkg;

    // Frame limits and field widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int SIZE_W     = 12;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W  = 1;
    localparam int MIN_SIZE   = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;

    // One result item waiting in the output buffer.
    typedef struct packed {
        coord_t row;
        coord_t col;
        pix_t   value;
        logic   filtered;
    } result_t;

    // Which results an item causes, worked out when it is taken in.
    typedef struct packed {
        logic has_bottom;
        logic has_edge;
        logic has_mid;
        logic filtered;
    } sched_t;

    // Clamps a frame dimension to the supported range.
    function automatic size_t clamp_size(input size_t value, input size_t max_value);
        size_t result;
        if (value < size_t'(MIN_SIZE))
        begin
            result = size_t'(MIN_SIZE);
        end
        else if (value > max_value)
        begin
            result = max_value;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

[hdl/mf3_pixel_if.sv]
interface mf3_pixel_if
    import mf3_pkg::*;
();
    logic valid;
    logic ready;
    pix_t pixel_value;
    logic frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

[hdl/mf3_result_if.sv]
interface mf3_result_if
    import mf3_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t out_row;
    coord_t out_col;
    pix_t   out_value;
    logic   was_filtered;
    logic   last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output was_filtered, output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input was_filtered, input last_of_run, output ready);
endinterface

[hdl/mf3_cfg_if.sv]
interface mf3_cfg_if
    import mf3_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    size_t                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/median_filter_3x3_unit.sv]
// Streaming 3x3 median filter for 8-bit gray frames sent in raster order. Interior pixels
// come out as the median of their 3x3 neighborhood, border pixels pass through unchanged,
// and every result carries its row and column, so results of the last column and the
// last row come out late and out of raster order. A pixel is taken every clock as long as
// it causes at most one result and the result receiver does not stall; a pixel that
// causes several results holds the single output register until all are sent, so input
// waits at row ends and through the last row. The first result of a pixel is shown after
// the read stage (line buffer read) and the window and median stage. The two line buffers
// are 2048 x 8 memories with a registered read port and need no clearing after reset.
// Width and height must be written by the user only while the filter is idle; the block
// itself does not enforce it. Values outside 3..2048 are clamped.
module median_filter_3x3_unit
    import mf3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mf3_pixel_if.sink    pixels,
    mf3_result_if.source results,
    mf3_cfg_if.sink      cfg
);

    // Configuration registers.
    size_t width_reg;
    size_t height_reg;

    // Frame position of the next item.
    coord_t row_reg;
    coord_t col_reg;

    // Line buffers.
    pix_t above_mem [MAX_WIDTH];
    pix_t two_mem   [MAX_WIDTH];

    // Read stage.
    logic   s1_valid_reg;
    pix_t   s1_px_reg;
    coord_t s1_row_reg;
    coord_t s1_col_reg;
    sched_t s1_sched_reg;
    pix_t   rd_above_reg;
    pix_t   rd_two_reg;
    logic   byp_reg;
    pix_t   byp_above_reg;
    pix_t   byp_two_reg;

    // Window and output buffer.
    pix_t    win_reg [9];
    pix_t    win_next [9];
    result_t slot_reg [3];
    logic [2:0] mask_reg;

    logic   pix_acc;
    logic   s1_adv;
    logic   s2_free;
    size_t  w_eff;
    size_t  h_eff;
    size_t  col_in;
    size_t  row_in;
    size_t  row_step;
    size_t  col_cur;
    size_t  row_cur;
    size_t  col_inc;
    size_t  row_inc;
    coord_t col_next;
    coord_t row_next;
    sched_t sched;
    pix_t   above_val;
    pix_t   two_val;
    pix_t   median;
    result_t slot_new [3];
    result_t head;

    // Median by rank: the element with exactly four smaller ones (ties broken by
    // position) sits in the middle of the sorted order.
    function automatic pix_t median9(input pix_t v [9]);
        logic [3:0] rank;
        pix_t       m;
        m = '0;
        for (int i = 0; i < 9; i++)
        begin
            rank = '0;
            for (int j = 0; j < 9; j++)
            begin
                if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)))
                begin
                    rank = rank + 4'd1;
                end
            end
            if (rank == 4'd4)
            begin
                m = v[i];
            end
        end
        return m;
    endfunction

    assign cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= size_t'(640);
            height_reg <= size_t'(480);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_WIDTH:  width_reg  <= cfg.data;
                REG_HEIGHT: height_reg <= cfg.data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Handshake of the stages.
    assign s2_free      = (mask_reg == 3'b000) || (results.ready && $onehot(mask_reg));
    assign s1_adv       = s1_valid_reg && s2_free;
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign pix_acc      = pixels.valid && pixels.ready;

    // Position of the incoming item, its successor and the results it causes.
    always_comb
    begin
        w_eff  = clamp_size(width_reg, size_t'(MAX_WIDTH));
        h_eff  = clamp_size(height_reg, size_t'(MAX_HEIGHT));
        col_in = pixels.frame_start ? '0 : {1'b0, col_reg};
        row_in = pixels.frame_start ? '0 : {1'b0, row_reg};
        if (col_in >= w_eff)
        begin
            col_cur  = '0;
            row_step = row_in + size_t'(1);
        end
        else
        begin
            col_cur  = col_in;
            row_step = row_in;
        end
        row_cur = (row_step >= h_eff) ? '0 : row_step;

        col_inc = col_cur + size_t'(1);
        row_inc = row_cur + size_t'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[COORD_W-1:0];
        end
        else
        begin
            col_next = col_inc[COORD_W-1:0];
            row_next = row_cur[COORD_W-1:0];
        end

        sched.has_mid    = (row_cur != '0) && (col_cur != '0);
        sched.filtered   = (row_cur >= size_t'(2)) && (col_cur >= size_t'(2));
        sched.has_edge   = (row_cur != '0) && (col_cur == w_eff - size_t'(1));
        sched.has_bottom = (row_cur == h_eff - size_t'(1));
    end

    // Position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (pix_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Line buffer one row above: read when an item is taken, written when it moves on.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            above_mem[s1_col_reg[ADDR_W-1:0]] <= s1_px_reg;
        end
        if (pix_acc)
        begin
            rd_above_reg <= above_mem[col_cur[ADDR_W-1:0]];
        end
    end

    // Line buffer two rows above.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            two_mem[s1_col_reg[ADDR_W-1:0]] <= above_val;
        end
        if (pix_acc)
        begin
            rd_two_reg <= two_mem[col_cur[ADDR_W-1:0]];
        end
    end

    // Read stage valid and bypass flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (pix_acc)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= s1_adv && (s1_col_reg == col_cur[COORD_W-1:0]);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Read stage payload. An item at the same column as the one leaving this stage
    // reads the buffers before that write lands, so it keeps the written values.
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_px_reg     <= pixels.pixel_value;
            s1_row_reg    <= row_cur[COORD_W-1:0];
            s1_col_reg    <= col_cur[COORD_W-1:0];
            s1_sched_reg  <= sched;
            byp_above_reg <= s1_px_reg;
            byp_two_reg   <= above_val;
        end
    end

    // New window column and the results of the item.
    always_comb
    begin
        above_val = byp_reg ? byp_above_reg : rd_above_reg;
        two_val   = byp_reg ? byp_two_reg : rd_two_reg;

        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = two_val;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = above_val;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;

        median = median9(win_next);

        slot_new[0].row      = s1_row_reg - coord_t'(1);
        slot_new[0].col      = s1_col_reg - coord_t'(1);
        slot_new[0].value    = s1_sched_reg.filtered ? median : win_next[4];
        slot_new[0].filtered = s1_sched_reg.filtered;

        slot_new[1].row      = s1_row_reg - coord_t'(1);
        slot_new[1].col      = s1_col_reg;
        slot_new[1].value    = above_val;
        slot_new[1].filtered = 1'b0;

        slot_new[2].row      = s1_row_reg;
        slot_new[2].col      = s1_col_reg;
        slot_new[2].value    = s1_px_reg;
        slot_new[2].filtered = 1'b0;
    end

    // Window register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    // Output buffer: the pending results of one item, sent lowest slot first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 3'b000;
        end
        else if (s1_adv)
        begin
            mask_reg <= {s1_sched_reg.has_bottom, s1_sched_reg.has_edge, s1_sched_reg.has_mid};
        end
        else if (results.ready)
        begin
            mask_reg <= mask_reg & (mask_reg - 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            slot_reg <= slot_new;
        end
    end

    // Result selection.
    always_comb
    begin
        priority if (mask_reg[0])
        begin
            head = slot_reg[0];
        end
        else if (mask_reg[1])
        begin
            head = slot_reg[1];
        end
        else
        begin
            head = slot_reg[2];
        end
    end

    assign results.valid        = (mask_reg != 3'b000);
    assign results.out_row      = head.row;
    assign results.out_col      = head.col;
    assign results.out_value    = head.value;
    assign results.was_filtered = head.filtered;
    assign results.last_of_run  = $onehot(mask_reg);

endmodule

[hdl/mf3_checker.sv]
`include "median_filter_3x3_unit_assert.svh"

module mf3_checker
    import mf3_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   res_valid,
    input logic   res_ready,
    input coord_t res_row,
    input coord_t res_col,
    input pix_t   res_value,
    input logic   res_filtered,
    input logic   res_last
);

    // No result is offered while reset is applied.
    `MF3_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> !res_valid, "result valid in reset")

    // A median is only ever produced for a pixel off the top and left border.
    `MF3_ASSERT(a_filtered_interior, clk, rst_n, res_valid && res_filtered |-> (res_row != '0) && (res_col != '0), "median on border")

    // A result that is not the last of its item is followed by another one.
    `MF3_ASSERT(a_run_continues, clk, rst_n, res_valid && res_ready && !res_last |=> res_valid, "result run cut short")

    // A result that is not taken stays unchanged.
    `MF3_ASSERT(a_stall_holds, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_col) && $stable(res_value) && $stable(res_filtered) && $stable(res_last), "stalled result changed")

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_row      (results.out_row),
    .res_col      (results.out_col),
    .res_value    (results.out_value),
    .res_filtered (results.was_filtered),
    .res_last     (results.last_of_run)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import mf3_pkg::*;

    // One pixel item waiting to be sent.
    typedef struct packed {
        pix_t value;
        logic frame_start;
    } pixel_item_t;

    // One filtered pixel that the filter is due to emit.
    typedef struct packed {
        coord_t row;
        coord_t col;
        pix_t   value;
        logic   filtered;
        logic   last;
    } filtered_pixel_t;

    // Gray level mixes for the random frames.
    typedef enum int {
        GRAY_UNIFORM,
        GRAY_EXTREMES,
        GRAY_NARROW
    } gray_mix_t;

    // Patterns of the result receiver.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    // Values driven onto the channels; they are known from time zero.
    logic                 pix_valid = 1'b0;
    pix_t                 pix_value = '0;
    logic                 pix_frame_start = 1'b0;
    logic                 res_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    size_t                cfg_data = '0;

    mf3_pixel_if  pixels ();
    mf3_result_if results ();
    mf3_cfg_if    cfg ();

    assign pixels.valid       = pix_valid;
    assign pixels.pixel_value = pix_value;
    assign pixels.frame_start = pix_frame_start;
    assign results.ready      = res_ready;
    assign cfg.valid          = cfg_valid;
    assign cfg.index          = cfg_index;
    assign cfg.data           = cfg_data;

    median_filter_3x3_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .results (results),
        .cfg     (cfg)
    );

    always #5 clk = ~clk;

    // Filter state as the testbench sees it.
    size_t       width_reg = 12'd640;
    size_t       height_reg = 12'd480;
    pix_t        line_above_mem [MAX_WIDTH];
    pix_t        line_two_above_mem [MAX_WIDTH];
    pix_t        window [9];
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    pixel_item_t     pixels_to_send [$];
    filtered_pixel_t outputs_due [$];
    int unsigned     pixels_queued = 0;
    int unsigned     pixels_taken = 0;
    int unsigned     error_count = 0;

    // Median of nine: the value with at most four below it and at least five not above it.
    function automatic pix_t median_of_window(input pix_t v [9]);
        int   below;
        int   not_above;
        pix_t result;
        result = v[0];
        for (int i = 0; i < 9; i++)
        begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                begin
                    below++;
                end
                if (v[j] <= v[i])
                begin
                    not_above++;
                end
            end
            if (below <= 4 && not_above >= 5)
            begin
                result = v[i];
            end
        end
        return result;
    endfunction

    // Takes one pixel into the filter state and queues the results it causes.
    task automatic filter_pixel(input pix_t px, input logic fs);
        int unsigned     w;
        int unsigned     h;
        int unsigned     r;
        int unsigned     c;
        int              n;
        filtered_pixel_t made [3];
        w = width_reg;
        h = height_reg;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < MIN_SIZE) h = MIN_SIZE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;

        // A frame start, or a size that shrank under the position, moves it first.
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
        begin
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        // Slide the window and bring in the new column from the line buffers.
        for (int i = 0; i < 3; i++)
        begin
            window[i * 3]     = window[i * 3 + 1];
            window[i * 3 + 1] = window[i * 3 + 2];
        end
        window[2] = line_two_above_mem[c];
        window[5] = line_above_mem[c];
        window[8] = px;
        line_two_above_mem[c] = line_above_mem[c];
        line_above_mem[c] = px;

        // The pixel up and to the left, the end of the row above, and the bottom row.
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            made[n].row = coord_t'(r - 1);
            made[n].col = coord_t'(c - 1);
            if (r >= 2 && c >= 2)
            begin
                made[n].value = median_of_window(window);
                made[n].filtered = 1'b1;
            end
            else
            begin
                made[n].value = window[4];
                made[n].filtered = 1'b0;
            end
            made[n].last = 1'b0;
            n++;
        end
        if (r >= 1 && c == w - 1)
        begin
            made[n].row = coord_t'(r - 1);
            made[n].col = coord_t'(c);
            made[n].value = window[5];
            made[n].filtered = 1'b0;
            made[n].last = 1'b0;
            n++;
        end
        if (r == h - 1)
        begin
            made[n].row = coord_t'(r);
            made[n].col = coord_t'(c);
            made[n].value = px;
            made[n].filtered = 1'b0;
            made[n].last = 1'b0;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            if (k == n - 1)
            begin
                made[k].last = 1'b1;
            end
            outputs_due.push_back(made[k]);
        end

        // Advance in raster order, wrapping at the end of the frame.
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        row_pos = r;
        col_pos = c;
    endtask

    // Pixel sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    pixel_item_t next_item;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (pix_valid && pixels.ready)
            begin
                filter_pixel(pix_value, pix_frame_start);
                pixels_taken++;
            end
            // A pixel that was not taken stays on the channel unchanged.
            if (!(pix_valid && !pixels.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix_valid <= 1'b0;
                end
                else if (pixels_to_send.size() > 0)
                begin
                    next_item = pixels_to_send.pop_front();
                    pix_valid <= 1'b1;
                    pix_value <= next_item.value;
                    pix_frame_start <= next_item.frame_start;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12)
                                                               : $urandom_range(0, 3);
                    end
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each item and stalls on a changing pattern.
    filtered_pixel_t due;
    stall_mode_t     stall_mode = STALL_NONE;
    int unsigned     stall_window = 0;
    int unsigned     stall_phase = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (results.valid && res_ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("result item with none due: row %0d col %0d value %0d",
                           results.out_row, results.out_col, results.out_value);
                    error_count++;
                end
                else
                begin
                    due = outputs_due.pop_front();
                    if (results.out_row !== due.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", due.row, results.out_row);
                        error_count++;
                    end
                    if (results.out_col !== due.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", due.col, results.out_col);
                        error_count++;
                    end
                    if (results.out_value !== due.value)
                    begin
                        $error("out_value: expected %0d, actual %0d",
                               due.value, results.out_value);
                        error_count++;
                    end
                    if (results.was_filtered !== due.filtered)
                    begin
                        $error("was_filtered: expected %0d, actual %0d",
                               due.filtered, results.was_filtered);
                        error_count++;
                    end
                    if (results.last_of_run !== due.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d",
                               due.last, results.last_of_run);
                        error_count++;
                    end
                end
            end

            // Pick a new stall pattern now and then.
            if (stall_window == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_window = $urandom_range(16, 160);
                stall_phase = 0;
            end
            else
            begin
                stall_window--;
            end
            stall_phase++;
            case (stall_mode)
                STALL_NONE:   res_ready <= 1'b1;
                STALL_RANDOM: res_ready <= ($urandom_range(0, 3) != 0);
                STALL_SPARSE: res_ready <= (stall_phase % 4 == 0);
                default:      res_ready <= (stall_phase % 24 >= 20);
            endcase
        end
    end

    function automatic pix_t next_gray(input gray_mix_t mix);
        pix_t result;
        case (mix)
            GRAY_EXTREMES:
            begin
                case ($urandom_range(0, 2))
                    0:       result = 8'h00;
                    1:       result = 8'hFF;
                    default: result = pix_t'($urandom_range(0, 255));
                endcase
            end
            GRAY_NARROW: result = pix_t'($urandom_range(100, 103));
            default:     result = pix_t'($urandom_range(0, 255));
        endcase
        return result;
    endfunction

    task automatic queue_pixel(input pix_t value, input logic fs);
        pixel_item_t item;
        item.value = value;
        item.frame_start = fs;
        pixels_to_send.push_back(item);
        pixels_queued++;
    endtask

    // Queues a run of random pixels; noise_odds of zero means no stray frame starts.
    task automatic queue_pixels(input int unsigned count, input logic fs_first,
                                input gray_mix_t mix, input int unsigned noise_odds);
        logic fs;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k == 0)
            begin
                fs = fs_first;
            end
            else
            begin
                fs = (noise_odds != 0 && $urandom_range(1, noise_odds) == 1);
            end
            queue_pixel(next_gray(mix), fs);
        end
    endtask

    // Waits until every pixel was taken and every result arrived, then lets the pipe settle.
    task automatic wait_idle();
        @(posedge clk);
        while (pixels_taken != pixels_queued || outputs_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Writes width and/or height in random order; called only while the filter is idle.
    task automatic program_size(input logic set_width, input logic set_height,
                                input size_t new_width, input size_t new_height);
        cfg_reg_t order [2];
        size_t    values [2];
        int       count;
        logic     width_first;
        count = 0;
        width_first = ($urandom_range(0, 1) == 1);
        if (set_width && width_first)
        begin
            order[count] = REG_WIDTH;
            values[count] = new_width;
            count++;
        end
        if (set_height)
        begin
            order[count] = REG_HEIGHT;
            values[count] = new_height;
            count++;
        end
        if (set_width && !width_first)
        begin
            order[count] = REG_WIDTH;
            values[count] = new_width;
            count++;
        end
        for (int k = 0; k < count; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data <= values[k];
            @(posedge clk);
            while (cfg.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            if (order[k] == REG_WIDTH)
            begin
                width_reg = values[k];
            end
            else
            begin
                height_reg = values[k];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Stimulus and end of run.
    initial
    begin
        pix_t        corner_frame [9];
        int unsigned random_count;
        int unsigned count;
        int unsigned count2;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned pick;
        size_t       new_w;
        size_t       new_h;
        size_t       w2;
        size_t       h2;
        gray_mix_t   mix;
        logic        at_origin;

        // Reset goes low with a real falling edge so the flops clear right away.
        #1 rst_n = 1'b0;

        corner_frame = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00};
        random_count = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_above_mem[i] = '0;
            line_two_above_mem[i] = '0;
        end
        for (int i = 0; i < 9; i++)
        begin
            window[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame with extreme gray levels around a single interior pixel.
        program_size(1'b1, 1'b1, 12'd3, 12'd3);
        for (int k = 0; k < 9; k++)
        begin
            queue_pixel(corner_frame[k], k == 0);
        end
        wait_idle();

        // Sizes below the minimum are clamped; the frame follows on by wrapping.
        program_size(1'b1, 1'b1, 12'd1, 12'd0);
        for (int k = 0; k < 8; k++)
        begin
            queue_pixel(pix_t'(1 << k), 1'b0);
        end
        queue_pixel(8'hFF, 1'b0);
        wait_idle();

        // Sizes above the maximum are clamped; a short run stays in the first row.
        program_size(1'b1, 1'b1, 12'hFFF, 12'hFFF);
        queue_pixels(16, 1'b1, GRAY_UNIFORM, 0);
        wait_idle();

        // A wide frame writes both line buffers over every column later frames use.
        program_size(1'b1, 1'b1, 12'd48, 12'd3);
        queue_pixels(3 * 48, 1'b1, GRAY_UNIFORM, 0);
        wait_idle();

        // Random frames, some with a size change in the middle of a frame.
        while (random_count < 150)
        begin
            mix = gray_mix_t'($urandom_range(0, 2));
            if ($urandom_range(0, 4) == 0)
            begin
                new_w = size_t'($urandom_range(5, 12));
                new_h = size_t'($urandom_range(5, 8));
                program_size(1'b1, 1'b1, new_w, new_h);
                count = 2 * new_w + $urandom_range(1, new_w * (new_h - 2) - 1);
                queue_pixels(count, 1'b1, mix, 0);
                wait_idle();

                // Change width, height or both while the frame is open.
                pick = $urandom_range(0, 2);
                w2 = size_t'($urandom_range(3, 14));
                h2 = size_t'($urandom_range(3, 8));
                program_size(pick != 1, pick != 0, w2, h2);
                eff_w = (pick != 1) ? w2 : new_w;
                eff_h = (pick != 0) ? h2 : new_h;
                count2 = $urandom_range(eff_w * eff_h, 2 * eff_w * eff_h);
                queue_pixels(count2, 1'b0, mix, 0);
                wait_idle();
                random_count += count + count2;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:       new_w = size_t'($urandom_range(0, 2));
                    1:       new_w = size_t'($urandom_range(13, 48));
                    default: new_w = size_t'($urandom_range(3, 12));
                endcase
                if ($urandom_range(0, 15) == 0)
                begin
                    new_h = size_t'($urandom_range(0, 2));
                end
                else
                begin
                    new_h = size_t'($urandom_range(3, 7));
                end
                program_size(1'b1, 1'b1, new_w, new_h);
                eff_w = (new_w < MIN_SIZE) ? MIN_SIZE : new_w;
                eff_h = (new_h < MIN_SIZE) ? MIN_SIZE : new_h;
                count = $urandom_range(1, 2) * eff_w * eff_h;

                // A frame that ended cleanly may go on without a frame start.
                at_origin = (row_pos == 0 && col_pos == 0);
                queue_pixels(count, at_origin ? ($urandom_range(0, 1) == 1) : 1'b1, mix,
                             ($urandom_range(0, 1) == 1) ? 48 : 0);
                wait_idle();
                random_count += count;
            end
        end

        if (error_count == 0 && outputs_due.size() == 0)
        begin
            $display("median_filter_3x3_unit regression: pass");
        end
        else
        begin
            $display("median_filter_3x3_unit regression: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("median_filter_3x3_unit regression: fail");
        $finish;
    end

endmodule
